// ===== design/eqpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// QRS peak detector package
// Shared constants for the QRS peak detector.
// ----------------------------------------------------------------------------
package eqpd_pkg;

  localparam int unsigned MaxWindowDefault  = 64;
  localparam int unsigned SampleBitsDefault = 12;
  localparam int unsigned LevelBits         = 24;
  localparam int unsigned SumBits           = 32;
  localparam int unsigned IndexBits         = 32;

  // Configuration register indexes.
  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegWeight = 2'd1;
  localparam logic [1:0] RegLearn  = 2'd2;
  // Unassigned index; writes to it are ignored.
  localparam logic [1:0] RegNone   = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQR  = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_THR  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ===== design/ecg_qrs_peak_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ECG QRS peak detector
// Squared derivative, moving average and adaptive R-peak threshold.
// ----------------------------------------------------------------------------
// One sample beat in gives one result beat out (the first sample after reset
// only primes the difference). A beat is processed by a bit-serial sequencer:
// a shift-and-add square, a window update, a restoring division of the window
// sum by the fill count, and a threshold step that includes its serial product.
// A new sample is taken only once the sequencer is back in idle, when the
// result of the last one has been loaded into the output register. During
// learning, except on its last sample, the threshold product is skipped.
// The result sits in an output register; the next sample is processed while it
// waits, and the sequencer only holds its own result (and so stalls the input)
// when the previous one is still untaken.
// Register writes are accepted only while the sequencer is idle.
module ecg_qrs_peak_detector
  import eqpd_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MaxWindowDefault,
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [LevelBits-1:0]        average,
  output logic                        r_peak,
  output logic [IndexBits-1:0]        sample_index,
  output logic                        learning
);

  localparam int unsigned PtrBits  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned LenBits  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DiffBits = SAMPLE_BITS + 1;
  localparam int unsigned SqBits   = 2 * DiffBits;
  localparam int unsigned CntBits  = $clog2(SumBits + 1);
  localparam logic [LevelBits-1:0] LevelMax = '1;

  // Configuration registers.
  logic [6:0]  window_length;
  logic [9:0]  threshold_weight;
  logic [15:0] learn_length;

  // Detector state.
  logic signed [SAMPLE_BITS-1:0] previous_sample;
  logic                          have_previous;
  logic [PtrBits-1:0]            write_pointer;
  logic [LenBits-1:0]            fill_count;
  logic [SumBits-1:0]            running_sum;
  logic [LevelBits-1:0]          signal_level;
  logic [LevelBits-1:0]          noise_level;
  logic [LevelBits-1:0]          peak_limit;
  logic [LevelBits-1:0]          noise_limit;
  logic [15:0]                   learn_count;
  logic [LevelBits-1:0]          learn_maximum;
  logic [IndexBits-1:0]          index_counter;

  // Working registers.
  state_t               state;
  logic [CntBits-1:0]   count;
  logic [DiffBits-1:0]  mcand;
  logic [DiffBits-1:0]  mplier;
  logic [SqBits-1:0]    product;
  logic [LevelBits-1:0] square;
  logic                 sum_phase;
  logic [SumBits-1:0]   quotient;
  logic [SumBits-1:0]   remainder;
  logic [LevelBits-1:0] avg_reg;
  logic                 thr_sign;
  logic [LevelBits-1:0] thr_mag;
  logic [9:0]           thr_mult;
  logic [LevelBits+10-1:0] thr_acc;
  logic                 peak_reg;
  logic                 learn_reg;

  // Window memory.
  logic [LevelBits-1:0] window_store [MAX_WINDOW];
  logic [LevelBits-1:0] old_entry;
  logic [PtrBits-1:0]   old_addr;

  // Effective lengths.
  logic [LenBits-1:0] eff_len;
  logic [15:0]        eff_learn;
  always_comb begin
    if (window_length == 7'd0) begin
      eff_len = LenBits'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      eff_len = LenBits'(MAX_WINDOW);
    end else begin
      eff_len = LenBits'(window_length);
    end
    eff_learn = (learn_length == 16'd0) ? 16'd1 : learn_length;
  end

  // Oldest entry lies eff_len slots behind the write pointer, wrapping.
  always_comb begin
    if (32'(write_pointer) >= 32'(eff_len)) begin
      old_addr = PtrBits'(32'(write_pointer) - 32'(eff_len));
    end else begin
      old_addr = PtrBits'(32'(write_pointer) + MAX_WINDOW - 32'(eff_len));
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SQR && count == '0) begin
      old_entry <= window_store[old_addr];
    end
    if (state == ST_SUM && !sum_phase) begin
      window_store[write_pointer] <= square;
    end
  end

  // Restoring divide step.
  logic [SumBits:0]   rem_shift;
  logic [SumBits:0]   rem_sub;
  always_comb begin
    rem_shift = {remainder, quotient[SumBits-1]};
    rem_sub   = rem_shift - (SumBits+1)'(fill_count);
  end

  // Next threshold, signed combination of noise level and scaled difference.
  logic [LevelBits+10-1:0] scaled;
  logic signed [LevelBits+2:0] thr_sum;
  always_comb begin
    scaled  = thr_acc >> 8;
    thr_sum = thr_sign ? ($signed({3'b000, noise_level}) - $signed({1'b0, scaled[LevelBits+1:0]}))
                       : ($signed({3'b000, noise_level}) + $signed({1'b0, scaled[LevelBits+1:0]}));
  end

  // Level update helpers.
  logic [LevelBits+2:0] sig_upd;
  logic [LevelBits+2:0] noi_upd;
  always_comb begin
    sig_upd = ((LevelBits+3)'(avg_reg) + (LevelBits+3)'(7) * (LevelBits+3)'(signal_level)) >> 3;
    noi_upd = ((LevelBits+3)'(avg_reg) + (LevelBits+3)'(7) * (LevelBits+3)'(noise_level)) >> 3;
  end

  logic signed [DiffBits-1:0] diff;
  assign diff = DiffBits'(signed'(sample)) - DiffBits'(previous_sample);

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  // The finished result moves to the output register once that register is free.
  logic out_load;
  assign out_load = (state == ST_THR) && sum_phase && (count >= CntBits'(12))
                    && (!out_valid || !out_stall);

  // Threshold product ran only when thr_mult was loaded this beat.
  logic thr_ran;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_ran <= 1'b0;
    end else if (state == ST_THR && count == CntBits'(1)) begin
      thr_ran <= 1'b1;
    end else if (state == ST_IDLE) begin
      thr_ran <= 1'b0;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= 7'd30;
      threshold_weight <= 10'd64;
      learn_length     <= 16'd100;
      previous_sample  <= '0;
      have_previous    <= 1'b0;
      write_pointer    <= '0;
      fill_count       <= '0;
      running_sum      <= '0;
      signal_level     <= '0;
      noise_level      <= '0;
      peak_limit       <= '0;
      noise_limit      <= '0;
      learn_count      <= '0;
      learn_maximum    <= '0;
      index_counter    <= '0;
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      count            <= '0;
      sum_phase        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegWindow: begin
            window_length <= cfg_data[6:0];
            write_pointer <= '0;
            fill_count    <= '0;
            running_sum   <= '0;
          end
          RegWeight: threshold_weight <= cfg_data[9:0];
          RegLearn:  learn_length     <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            previous_sample <= signed'(sample);
            if (have_previous) begin
              mcand   <= diff[DiffBits-1] ? DiffBits'(-diff) : DiffBits'(diff);
              mplier  <= diff[DiffBits-1] ? DiffBits'(-diff) : DiffBits'(diff);
              product <= '0;
              count   <= '0;
              state   <= ST_SQR;
            end
            have_previous <= 1'b1;
          end
        end
        // Shift-and-add square, one multiplier bit a cycle.
        ST_SQR: begin
          if (mplier[0]) begin
            product <= product + (SqBits'(mcand) << count);
          end
          mplier <= mplier >> 1;
          if (32'(count) == DiffBits - 1) begin
            state     <= ST_SUM;
            sum_phase <= 1'b0;
          end
          count <= count + 1'b1;
        end
        // Window update, then divide setup.
        ST_SUM: begin
          if (!sum_phase) begin
            running_sum <= running_sum + SumBits'(square)
                           - ((fill_count >= eff_len) ? SumBits'(old_entry) : '0);
            write_pointer <= (32'(write_pointer) == MAX_WINDOW - 1) ? '0
                                                                    : write_pointer + 1'b1;
            if (fill_count < eff_len) begin
              fill_count <= fill_count + 1'b1;
            end else begin
              fill_count <= eff_len;
            end
            sum_phase <= 1'b1;
          end else begin
            quotient  <= running_sum;
            remainder <= '0;
            count     <= '0;
            state     <= ST_DIV;
          end
        end
        // Restoring division of the sum by the fill count.
        ST_DIV: begin
          if (!rem_sub[SumBits]) begin
            remainder <= rem_sub[SumBits-1:0];
            quotient  <= {quotient[SumBits-2:0], 1'b1};
          end else begin
            remainder <= rem_shift[SumBits-1:0];
            quotient  <= {quotient[SumBits-2:0], 1'b0};
          end
          if (32'(count) == SumBits - 1) begin
            state <= ST_THR;
            count <= '0;
            sum_phase <= 1'b0;
          end else begin
            count <= count + 1'b1;
          end
        end
        // Detection decision, then serial threshold product.
        ST_THR: begin
          if (!sum_phase) begin
            avg_reg   <= (quotient > SumBits'(LevelMax)) ? LevelMax
                                                         : quotient[LevelBits-1:0];
            sum_phase <= 1'b1;
            count     <= '0;
            peak_reg  <= 1'b0;
            learn_reg <= 1'b0;
          end else if (count == '0) begin
            // Apply level updates.
            if (learn_count < eff_learn) begin
              learn_reg <= 1'b1;
              if (learn_count + 16'd1 >= eff_learn) begin
                signal_level <= ((avg_reg > learn_maximum) ? avg_reg : learn_maximum) >> 3;
                noise_level  <= ((avg_reg > learn_maximum) ? avg_reg : learn_maximum) >> 3;
                count <= count + 1'b1;
              end else begin
                count <= CntBits'(12);
              end
              if (avg_reg > learn_maximum) begin
                learn_maximum <= avg_reg;
              end
              learn_count <= learn_count + 16'd1;
            end else begin
              if (avg_reg > peak_limit) begin
                peak_reg     <= 1'b1;
                signal_level <= sig_upd[LevelBits-1:0];
              end else if (avg_reg > noise_limit) begin
                noise_level <= noi_upd[LevelBits-1:0];
              end
              count <= count + 1'b1;
            end
          end else if (count == CntBits'(1)) begin
            thr_sign <= signal_level < noise_level;
            thr_mag  <= (signal_level < noise_level) ? noise_level - signal_level
                                                     : signal_level - noise_level;
            thr_mult <= threshold_weight;
            thr_acc  <= '0;
            count    <= count + 1'b1;
          end else if (count < CntBits'(12)) begin
            // One weight bit a cycle.
            if (thr_mult[0]) begin
              thr_acc <= thr_acc + ((LevelBits+10)'(thr_mag) << (count - CntBits'(2)));
            end
            thr_mult <= thr_mult >> 1;
            count    <= count + 1'b1;
          end else if (out_load) begin
            if (thr_ran) begin
              if (thr_sum < 0) begin
                peak_limit  <= '0;
                noise_limit <= '0;
              end else if (thr_sum > $signed({3'b000, LevelMax})) begin
                peak_limit  <= LevelMax;
                noise_limit <= LevelMax >> 1;
              end else begin
                peak_limit  <= thr_sum[LevelBits-1:0];
                noise_limit <= thr_sum[LevelBits-1:0] >> 1;
              end
            end
            average      <= avg_reg;
            r_peak       <= peak_reg;
            learning     <= learn_reg;
            sample_index <= index_counter;
            index_counter <= index_counter + 1'b1;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Square register follows the product, saturated to the level width.
  always_ff @(posedge clk) begin
    if (state == ST_SUM && sum_phase == 1'b0) begin
      square <= square;
    end else if (SqBits > LevelBits && |(product >> LevelBits)) begin
      square <= LevelMax;
    end else begin
      square <= LevelBits'(product);
    end
  end

  // Assertions.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= LenBits'(MAX_WINDOW))
    else $error("fill count beyond window depth");
  a_thr_order: assert property (@(posedge clk) disable iff (rst)
    noise_limit <= peak_limit)
    else $error("noise threshold above peak threshold");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample_index)))
    else $error("result beat dropped while stalled");

endmodule
`default_nettype wire
